### hdl/frwm_pkg.sv
// Shared widths, constants and divider handshake types for the frame rate window meter.
package frwm_pkg;

    localparam int RATE_W    = 25;
    localparam int ELAPSED_W = 25;
    localparam int COUNT_W   = 16;
    localparam int UPS_CNT_W = 17;
    localparam int DELTA_W   = 20;
    localparam int SKIP_W    = 16;
    localparam int WS_W      = 6;
    localparam int PERIOD_W  = 24;
    localparam int NUM_W     = 45;
    localparam int DIV_W     = 25;
    localparam int STEP_W    = 6;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [NUM_W-1:0]     US_PER_S_Q8  = 45'd256000000;
    localparam logic [RATE_W-1:0]    RATE_MAX     = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX    = '1;
    localparam logic [WS_W-1:0]      WINDOW_RESET = 6'd30;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 24'd1000000;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SKIP = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [RATE_W-1:0] quotient;
    } div_rsp_t;

endpackage

### hdl/frwm_item_if.sv
// Input request channel carrying one frame tick or skip request.
interface frwm_item_if import frwm_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [DELTA_W-1:0] delta_us;
    logic [SKIP_W-1:0]  skip_add;

    modport source (output valid, cmd, delta_us, skip_add, input ready);
    modport sink (input valid, cmd, delta_us, skip_add, output ready);

endinterface

### hdl/frwm_result_if.sv
// Result request channel carrying the current and averaged rates.
interface frwm_result_if import frwm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              sampled;
    logic [RATE_W-1:0] current_fps;
    logic [RATE_W-1:0] current_ups;
    logic [RATE_W-1:0] average_fps;
    logic [RATE_W-1:0] average_ups;

    modport source (output valid, sampled, current_fps, current_ups, average_fps,
                    average_ups, input ready);
    modport sink (input valid, sampled, current_fps, current_ups, average_fps,
                  average_ups, output ready);

endinterface

### hdl/frwm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module frwm_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/frwm_div.sv
// Restoring divider that retires one quotient bit per cycle with an overflow flag.
module frwm_div import frwm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output div_rsp_t         rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [RATE_W-1:0] quo_reg;
    logic              ovf_reg;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;
    logic [DIV_W-1:0]  rem_step;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_step = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[RATE_W-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[RATE_W-1];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.ovf      = ovf_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/frame_rate_window_meter.sv
// Frame rate window meter top level: accumulators, sample sequencer, rate ring and APB registers.
// A request that closes no period goes from the idle state to the done state, then into the output register.
// A closing frame tick passes through a multiply state, then four passes through one bit-per-cycle divider:
// current fps and ups over NUM_W steps each, then the fps and ups averages over SUM_W steps each.
// One request is handled at a time; the next is taken once the result sits in the output register.
// Asynchronous active-low reset clears all counters, latest and mean rates and ring valid bits; no clearing pass.
module frame_rate_window_meter import frwm_pkg::*; #(
    parameter int MAX_WINDOW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    frwm_item_if.sink         item,
    frwm_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W   = RATE_W + WIN_W;
    localparam int CMP_W   = (WIN_W > WS_W) ? WIN_W : WS_W;
    localparam int ENTRY_W = 2 * RATE_W;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MUL      = 7'b0000010,
        ST_DIV_FPS  = 7'b0000100,
        ST_DIV_UPS  = 7'b0001000,
        ST_DIV_FAVG = 7'b0010000,
        ST_DIV_UAVG = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic                 go_reg;
    logic                 go_next;

    logic [WS_W-1:0]      window_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [COUNT_W-1:0]   frame_reg;
    logic [COUNT_W-1:0]   skip_reg;
    logic [RATE_W-1:0]    fps_latest_reg;
    logic [RATE_W-1:0]    ups_latest_reg;
    logic [RATE_W-1:0]    fps_mean_reg;
    logic [RATE_W-1:0]    ups_mean_reg;
    logic [IDX_W-1:0]     ring_idx_reg;
    logic                 ring_full_reg;
    logic [MAX_WINDOW-1:0] ring_vld_reg;
    logic [SUM_W-1:0]     fps_sum_reg;
    logic [SUM_W-1:0]     ups_sum_reg;
    logic                 sampled_reg;

    logic [ELAPSED_W-1:0] samp_elapsed_reg;
    logic [COUNT_W-1:0]   samp_frames_reg;
    logic [UPS_CNT_W-1:0] samp_ups_reg;
    logic [NUM_W-1:0]     prod_fps_reg;
    logic [NUM_W-1:0]     prod_ups_reg;
    logic [RATE_W-1:0]    old_fps_reg;
    logic [RATE_W-1:0]    old_ups_reg;

    logic                 out_vld_reg;
    logic                 out_sampled_reg;
    logic [RATE_W-1:0]    out_fps_reg;
    logic [RATE_W-1:0]    out_ups_reg;
    logic [RATE_W-1:0]    out_favg_reg;
    logic [RATE_W-1:0]    out_uavg_reg;

    logic                 cfg_wr;
    logic                 accept;
    logic                 out_free;
    logic [CMP_W-1:0]     ws_wide;
    logic [WIN_W-1:0]     win_eff;
    logic [IDX_W-1:0]     idx_eff;
    logic [WIN_W-1:0]     idx_inc;
    logic [WIN_W-1:0]     filled;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic [ELAPSED_W-1:0] elapsed_sat;
    logic [COUNT_W-1:0]   frame_inc;
    logic [COUNT_W:0]     skip_sum;
    logic [COUNT_W-1:0]   skip_sat;
    logic                 close;
    logic [RATE_W-1:0]    rate_q;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [RATE_W-1:0]    old_fps;
    logic [RATE_W-1:0]    old_ups;

    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic [NUM_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_divisor;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_PERIOD) ? APB_DW'(period_reg) : APB_DW'(window_reg);

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_vld_reg || result.ready;

    always_comb
    begin
        ws_wide = CMP_W'(window_reg);
        if (ws_wide == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (ws_wide > CMP_W'(MAX_WINDOW))
        begin
            win_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = WIN_W'(ws_wide);
        end
        idx_eff = (WIN_W'(ring_idx_reg) >= win_eff) ? '0 : ring_idx_reg;
        idx_inc = WIN_W'(idx_eff) + 1'b1;
        filled  = ring_full_reg ? win_eff : WIN_W'(ring_idx_reg);

        elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(item.delta_us);
        elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
        frame_inc   = (frame_reg == COUNT_MAX) ? frame_reg : frame_reg + 1'b1;
        skip_sum    = {1'b0, skip_reg} + {1'b0, item.skip_add};
        skip_sat    = skip_sum[COUNT_W] ? COUNT_MAX : skip_sum[COUNT_W-1:0];
        close       = elapsed_sat > ELAPSED_W'(period_reg);

        rate_q  = div_rsp.ovf ? RATE_MAX : div_rsp.quotient;
        old_fps = ring_vld_reg[idx_eff] ? ram_rdata[ENTRY_W-1:RATE_W] : '0;
        old_ups = ring_vld_reg[idx_eff] ? ram_rdata[RATE_W-1:0] : '0;
        ram_we  = (state_reg == ST_DIV_UPS) && div_rsp.done;
    end

    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_TICK && close)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV_FPS;
                go_next    = 1'b1;
            end
            ST_DIV_FPS:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_UPS;
                    go_next    = 1'b1;
                end
            end
            ST_DIV_UPS:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_FAVG;
                    go_next    = 1'b1;
                end
            end
            ST_DIV_FAVG:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_UAVG;
                    go_next    = 1'b1;
                end
            end
            ST_DIV_UAVG:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_req.start = go_reg;
        div_req.steps = STEP_W'(NUM_W);
        div_dividend  = '0;
        div_divisor   = '0;
        case (state_reg)
            ST_DIV_FPS:
            begin
                div_dividend = prod_fps_reg;
                div_divisor  = samp_elapsed_reg;
            end
            ST_DIV_UPS:
            begin
                div_dividend = prod_ups_reg;
                div_divisor  = samp_elapsed_reg;
            end
            ST_DIV_FAVG:
            begin
                div_req.steps = STEP_W'(SUM_W);
                div_dividend  = NUM_W'(fps_sum_reg) << (NUM_W - SUM_W);
                div_divisor   = DIV_W'(filled);
            end
            ST_DIV_UAVG:
            begin
                div_req.steps = STEP_W'(SUM_W);
                div_dividend  = NUM_W'(ups_sum_reg) << (NUM_W - SUM_W);
                div_divisor   = DIV_W'(filled);
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            go_reg         <= 1'b0;
            window_reg     <= WINDOW_RESET;
            period_reg     <= PERIOD_RESET;
            elapsed_reg    <= '0;
            frame_reg      <= '0;
            skip_reg       <= '0;
            fps_latest_reg <= '0;
            ups_latest_reg <= '0;
            fps_mean_reg   <= '0;
            ups_mean_reg   <= '0;
            ring_idx_reg   <= '0;
            ring_full_reg  <= 1'b0;
            ring_vld_reg   <= '0;
            fps_sum_reg    <= '0;
            ups_sum_reg    <= '0;
            sampled_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;

            if (cfg_wr)
            begin
                if (paddr[2] == REG_WINDOW)
                begin
                    window_reg    <= pwdata[WS_W-1:0];
                    ring_idx_reg  <= '0;
                    ring_full_reg <= 1'b0;
                    ring_vld_reg  <= '0;
                    fps_sum_reg   <= '0;
                    ups_sum_reg   <= '0;
                end
                else
                begin
                    period_reg <= pwdata[PERIOD_W-1:0];
                end
            end

            if (accept)
            begin
                sampled_reg <= (item.cmd == CMD_TICK) && close;
                if (item.cmd == CMD_SKIP)
                begin
                    skip_reg <= skip_sat;
                end
                else if (close)
                begin
                    elapsed_reg <= '0;
                    frame_reg   <= '0;
                    skip_reg    <= '0;
                end
                else
                begin
                    elapsed_reg <= elapsed_sat;
                    frame_reg   <= frame_inc;
                end
            end

            if (state_reg == ST_DIV_FPS && div_rsp.done)
            begin
                fps_latest_reg <= rate_q;
            end

            if (ram_we)
            begin
                ups_latest_reg        <= rate_q;
                ring_vld_reg[idx_eff] <= 1'b1;
                fps_sum_reg <= fps_sum_reg + SUM_W'(fps_latest_reg) - SUM_W'(old_fps_reg);
                ups_sum_reg <= ups_sum_reg + SUM_W'(rate_q) - SUM_W'(old_ups_reg);
                if (idx_inc >= win_eff)
                begin
                    ring_idx_reg  <= '0;
                    ring_full_reg <= 1'b1;
                end
                else
                begin
                    ring_idx_reg <= IDX_W'(idx_inc);
                end
            end

            if (state_reg == ST_DIV_FAVG && div_rsp.done)
            begin
                fps_mean_reg <= rate_q;
            end

            if (state_reg == ST_DIV_UAVG && div_rsp.done)
            begin
                ups_mean_reg <= rate_q;
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_elapsed_reg <= elapsed_sat;
            samp_frames_reg  <= frame_inc;
            samp_ups_reg     <= {1'b0, frame_inc} + {1'b0, skip_reg};
        end
        if (state_reg == ST_MUL)
        begin
            prod_fps_reg <= NUM_W'(samp_frames_reg) * US_PER_S_Q8;
            prod_ups_reg <= NUM_W'(samp_ups_reg) * US_PER_S_Q8;
            old_fps_reg  <= old_fps;
            old_ups_reg  <= old_ups;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_sampled_reg <= sampled_reg;
            out_fps_reg     <= fps_latest_reg;
            out_ups_reg     <= ups_latest_reg;
            out_favg_reg    <= fps_mean_reg;
            out_uavg_reg    <= ups_mean_reg;
        end
    end

    frwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_eff),
        .wdata ({fps_latest_reg, rate_q}),
        .re    (accept),
        .raddr (idx_eff),
        .rdata (ram_rdata)
    );

    frwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp)
    );

    assign result.valid       = out_vld_reg;
    assign result.sampled     = out_sampled_reg;
    assign result.current_fps = out_fps_reg;
    assign result.current_ups = out_ups_reg;
    assign result.average_fps = out_favg_reg;
    assign result.average_ups = out_uavg_reg;

`ifndef SYNTHESIS
    a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        WIN_W'(ring_idx_reg) < win_eff)
        else $error("ring index outside the active window");

    a_accum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_FPS |-> elapsed_reg == '0 && frame_reg == '0 && skip_reg == '0)
        else $error("period accumulators not cleared during a sample");

    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV_FPS || state_reg == ST_DIV_UPS ||
                         state_reg == ST_DIV_FAVG || state_reg == ST_DIV_UAVG)
        else $error("divider finished outside a divide state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_full_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ring_full_reg |-> ring_vld_reg[ring_idx_reg])
        else $error("full ring points at an unwritten entry");
`endif

endmodule
